/* hdl/bandpass_envelope_follower_macros.svh */
// Assertion macros for the bandpass envelope follower.
// Each macro expects clk and rst in scope at the point of use.
`ifndef BANDPASS_ENVELOPE_FOLLOWER_MACROS_SVH
`define BANDPASS_ENVELOPE_FOLLOWER_MACROS_SVH

// same-cycle implication
`define BEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// fixed latency
`define BEF_ASSERT_LAT3(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

/* hdl/bef_pkg.sv */
// Shared types, constants and fixed-point helpers for the bandpass envelope follower.
// No dependencies.
package bef_pkg;

  localparam int ACC_W      = 40;
  localparam int WIDE_W     = 64;
  localparam int COEF_W     = 18;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int MUL_SPLIT  = 20;
  localparam int ENV_W      = 32;
  localparam int ALPHA_FRAC = 16;

  localparam logic [GAIN_W-1:0] ALPHA_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_ALPHA = 3'd6;

  localparam logic [GAIN_W-1:0]        HP_GAIN_RST   = 17'd59963;
  localparam logic signed [COEF_W-1:0] HP_FB1_RST    = -18'sd119452;
  localparam logic signed [COEF_W-1:0] HP_FB2_RST    = 18'sd54866;
  localparam logic [GAIN_W-1:0]        LP_GAIN_RST   = 17'd3023;
  localparam logic signed [COEF_W-1:0] LP_FB1_RST    = -18'sd85674;
  localparam logic signed [COEF_W-1:0] LP_FB2_RST    = 18'sd32231;
  localparam logic [GAIN_W-1:0]        ENV_ALPHA_RST = 17'd10923;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam wide_t ACC_MAX = (wide_t'(1) <<< (ACC_W - 1)) - wide_t'(1);
  localparam wide_t ACC_MIN = -(wide_t'(1) <<< (ACC_W - 1));

  typedef struct packed {
    logic                     start;
    logic signed [COEF_W-1:0] coef;
    acc_t                     opnd;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    wide_t prod;
  } mul_rsp_t;

  // round half up: floor((v + 2^(sh-1)) / 2^sh)
  function automatic wide_t rnd(wide_t v, int sh);
    return (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic acc_t sat40(wide_t v);
    wide_t c;
    if (v > ACC_MAX) c = ACC_MAX;
    else if (v < ACC_MIN) c = ACC_MIN;
    else c = v;
    return c[ACC_W-1:0];
  endfunction

endpackage

/* hdl/bef_in_if.sv */
// Input channel of the bandpass envelope follower: valid/ready plus one sample.
// No dependencies.
interface bef_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/bef_out_if.sv */
// Output channel of the bandpass envelope follower: valid/ready plus band value and envelope.
// No dependencies.
interface bef_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] band_value;
  logic [SAMPLE_BITS-2:0]        envelope;

  modport source (output valid, output band_value, output envelope, input ready);
  modport sink   (input valid, input band_value, input envelope, output ready);
endinterface

/* hdl/bandpass_envelope_follower.sv */
// Top level: highpass and lowpass biquads (transposed direct form II) and envelope follower,
// sequenced over one shared multiplier. Depends on bef_pkg, bef_in_if, bef_out_if, bef_mul.
//
//  channel | dir | handshake            | payload
//  din     | in  | din.valid/din.ready  | sample
//  dout    | out | dout.valid/dout.ready| band_value, envelope
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// Seven products run in turn on the single 18x20 multiplier, each as an issue, two passes and
// a result step; the accept cycle comes before them and the output load after them.
// din.ready is high only while no sample is in flight; the result sits in an output register.
// A stalled output holds the sequencer in its last step until the register frees.
// rst is synchronous: filter state and envelope clear, coefficients load their defaults.
`include "bandpass_envelope_follower_macros.svh"

module bandpass_envelope_follower #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bef_pkg::CFG_DATA_W-1:0]  cfg_data,
  bef_in_if.sink                          din,
  bef_out_if.source                       dout
);
  import bef_pkg::*;

  localparam int    ENV_FRAC = ENV_W - SAMPLE_BITS;
  localparam wide_t SMAX     = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - wide_t'(1);
  localparam wide_t SMIN     = -(wide_t'(1) <<< (SAMPLE_BITS - 1));
  localparam wide_t ENV_MAX  = (wide_t'(1) <<< ENV_W) - wide_t'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GX   = 4'd1;
  localparam logic [3:0] S_Y    = 4'd2;
  localparam logic [3:0] S_A1   = 4'd3;
  localparam logic [3:0] S_N1   = 4'd4;
  localparam logic [3:0] S_A2   = 4'd5;
  localparam logic [3:0] S_N2   = 4'd6;
  localparam logic [3:0] S_AL   = 4'd7;
  localparam logic [3:0] S_ENV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;
  logic       sec;        // 0: highpass, 1: lowpass
  logic       out_valid;

  logic [GAIN_W-1:0]        hp_gain, lp_gain, env_alpha;
  logic signed [COEF_W-1:0] hp_fb1, hp_fb2, lp_fb1, lp_fb2;

  acc_t             hp_acc1, hp_acc2, lp_acc1, lp_acc2;
  logic [ENV_W-1:0] env_level;

  acc_t                          xs;
  acc_t                          y_r;
  wide_t                         pgx;
  acc_t                          diff_r;
  logic signed [SAMPLE_BITS-1:0] band_r;
  logic signed [SAMPLE_BITS-1:0] band_out;
  logic [SAMPLE_BITS-2:0]        env_out;

  mul_req_t req;
  mul_rsp_t rsp;

  logic                     accept, out_free, mul_wait;
  logic [GAIN_W-1:0]        g_sel, alpha_eff;
  logic signed [COEF_W-1:0] a1_sel, a2_sel;
  acc_t                     w1_sel, w2_sel;
  acc_t                     x_scaled, y_calc, n1_calc, n2_calc;
  wide_t                    two_p, n1_raw;
  wide_t                    band_w, band_sat, mag, diff_w;
  wide_t                    env_wide, env_sum, env_clamp, e_w, e_sat;
  logic [ENV_W-1:0]         env_new;

  bef_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign accept   = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;
  assign mul_wait = (state == S_Y) || (state == S_N1) || (state == S_N2) || (state == S_ENV);

  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = out_valid;
  assign dout.band_value = band_out;
  assign dout.envelope   = env_out;

  assign g_sel     = sec ? lp_gain : hp_gain;
  assign a1_sel    = sec ? lp_fb1  : hp_fb1;
  assign a2_sel    = sec ? lp_fb2  : hp_fb2;
  assign w1_sel    = sec ? lp_acc1 : hp_acc1;
  assign w2_sel    = sec ? lp_acc2 : hp_acc2;
  assign alpha_eff = (env_alpha > ALPHA_ONE) ? ALPHA_ONE : env_alpha;

  // section arithmetic
  assign x_scaled = sat40(wide_t'(din.sample) <<< COEF_FRAC_BITS);
  assign y_calc   = sat40(rnd(rsp.prod, COEF_FRAC_BITS) + wide_t'(w1_sel));
  assign two_p    = pgx <<< 1;
  assign n1_raw   = sec ? (two_p - rsp.prod) : (-two_p - rsp.prod);
  assign n1_calc  = sat40(rnd(n1_raw, COEF_FRAC_BITS) + wide_t'(w2_sel));
  assign n2_calc  = sat40(rnd(pgx - rsp.prod, COEF_FRAC_BITS));

  // band value, rectifier and envelope
  assign env_wide = wide_t'({{(WIDE_W-ENV_W){1'b0}}, env_level});
  always_comb begin
    band_w = rnd(wide_t'(y_r), COEF_FRAC_BITS);
    if (band_w > SMAX) band_sat = SMAX;
    else if (band_w < SMIN) band_sat = SMIN;
    else band_sat = band_w;
    mag    = (band_sat < 0) ? -band_sat : band_sat;
    diff_w = (mag <<< ENV_FRAC) - env_wide;

    env_sum = env_wide + rnd(rsp.prod, ALPHA_FRAC);
    if (env_sum < 0) env_clamp = '0;
    else if (env_sum > ENV_MAX) env_clamp = ENV_MAX;
    else env_clamp = env_sum;
    env_new = env_clamp[ENV_W-1:0];

    e_w   = rnd(env_wide, ENV_FRAC);
    e_sat = (e_w > SMAX) ? SMAX : e_w;
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_GX: begin
        req.start = 1'b1;
        req.coef  = {1'b0, g_sel};
        req.opnd  = xs;
      end
      S_A1: begin
        req.start = 1'b1;
        req.coef  = a1_sel;
        req.opnd  = y_r;
      end
      S_A2: begin
        req.start = 1'b1;
        req.coef  = a2_sel;
        req.opnd  = y_r;
      end
      S_AL: begin
        req.start = 1'b1;
        req.coef  = {1'b0, alpha_eff};
        req.opnd  = diff_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sec       <= 1'b0;
      out_valid <= 1'b0;
      hp_gain   <= HP_GAIN_RST;
      hp_fb1    <= HP_FB1_RST;
      hp_fb2    <= HP_FB2_RST;
      lp_gain   <= LP_GAIN_RST;
      lp_fb1    <= LP_FB1_RST;
      lp_fb2    <= LP_FB2_RST;
      env_alpha <= ENV_ALPHA_RST;
      hp_acc1   <= '0;
      hp_acc2   <= '0;
      lp_acc1   <= '0;
      lp_acc2   <= '0;
      env_level <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HP_GAIN:   hp_gain   <= cfg_data[GAIN_W-1:0];
          REG_HP_FB1:    hp_fb1    <= cfg_data;
          REG_HP_FB2:    hp_fb2    <= cfg_data;
          REG_LP_GAIN:   lp_gain   <= cfg_data[GAIN_W-1:0];
          REG_LP_FB1:    lp_fb1    <= cfg_data;
          REG_LP_FB2:    lp_fb2    <= cfg_data;
          REG_ENV_ALPHA: env_alpha <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && dout.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: if (accept) begin
          state <= S_GX;
          sec   <= 1'b0;
        end
        S_GX: state <= S_Y;
        S_Y:  if (rsp.done) state <= S_A1;
        S_A1: state <= S_N1;
        S_N1: if (rsp.done) begin
          if (sec) lp_acc1 <= n1_calc;
          else hp_acc1 <= n1_calc;
          state <= S_A2;
        end
        S_A2: state <= S_N2;
        S_N2: if (rsp.done) begin
          if (sec) begin
            lp_acc2 <= n2_calc;
            state   <= S_AL;
          end else begin
            hp_acc2 <= n2_calc;
            sec     <= 1'b1;
            state   <= S_GX;
          end
        end
        S_AL:  state <= S_ENV;
        S_ENV: if (rsp.done) begin
          env_level <= env_new;
          state     <= S_OUT;
        end
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) xs <= x_scaled;
      S_Y: if (rsp.done) begin
        y_r <= y_calc;
        pgx <= rsp.prod;
      end
      S_N2: if (rsp.done) begin
        if (sec) begin
          band_r <= band_sat[SAMPLE_BITS-1:0];
          diff_r <= diff_w[ACC_W-1:0];
        end else begin
          xs <= y_r;
        end
      end
      S_OUT: if (out_free) begin
        band_out <= band_r;
        env_out  <= e_sat[SAMPLE_BITS-2:0];
      end
      default: ;
    endcase
  end

  `BEF_ASSERT_NOW(a_done_in_wait, rsp.done, mul_wait, "product returned outside a wait step")
  `BEF_ASSERT_NEXT(a_accept_start, accept, state == S_GX && !sec, "transaction did not start")
  `BEF_ASSERT_NEXT(a_out_load, state == S_OUT && out_free, out_valid && din.ready, "no result")

endmodule

/* hdl/bef_mul.sv */
// Shared multiplier: 18-bit signed coefficient times 40-bit signed operand, in two passes
// over a 20-bit split of the operand. Depends on bef_pkg and the assertion macros.
`include "bandpass_envelope_follower_macros.svh"

module bef_mul (
  input  logic              clk,
  input  logic              rst,
  input  bef_pkg::mul_req_t req,
  output bef_pkg::mul_rsp_t rsp
);
  import bef_pkg::*;

  localparam int HI_W = ACC_W - MUL_SPLIT;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;

  logic [1:0]                            phase;
  logic                                  done_r;
  logic signed [COEF_W-1:0]              coef_r;
  acc_t                                  opnd_r;
  logic signed [COEF_W+HI_W-1:0]         hi_r;
  logic signed [MUL_SPLIT:0]             opnd_part;
  logic signed [COEF_W+MUL_SPLIT:0]      pprod;
  wide_t                                 prod_r;

  // upper half sign-extended, lower half zero-extended
  assign opnd_part = (phase == PH_HI) ? {opnd_r[ACC_W-1], opnd_r[ACC_W-1:MUL_SPLIT]}
                                      : {1'b0, opnd_r[MUL_SPLIT-1:0]};
  assign pprod     = coef_r * opnd_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (phase == PH_LO);
      unique case (phase)
        PH_IDLE: if (req.start) phase <= PH_HI;
        PH_HI:   phase <= PH_LO;
        PH_LO:   phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && req.start) begin
      coef_r <= req.coef;
      opnd_r <= req.opnd;
    end
    if (phase == PH_HI) hi_r <= pprod[COEF_W+HI_W-1:0];
    if (phase == PH_LO) prod_r <= (wide_t'(hi_r) <<< MUL_SPLIT) + wide_t'(pprod);
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

  `BEF_ASSERT_NOW(a_start_idle, req.start, phase == PH_IDLE, "multiplier started while busy")
  `BEF_ASSERT_LAT3(a_done_lat, req.start, done_r, "multiplier result late or missing")

endmodule

/* test/bef_band_checker.sv */
`timescale 1ns / 100ps
// Checker for the bandpass envelope follower: follows register writes, predicts band value
// and envelope for every accepted sample and compares each result transaction in order.
// Depends on bef_pkg, bef_in_if and bef_out_if.
module bef_band_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bef_pkg::CFG_DATA_W-1:0] cfg_data,
  bef_in_if                              din,
  bef_out_if                             dout,
  output int                             errors,
  output int                             pending
);

  localparam longint ACC_HI      = (longint'(1) <<< 39) - 1;
  localparam longint ACC_LO      = -(longint'(1) <<< 39);
  localparam longint ENV_CEIL    = 64'sh0000_0000_FFFF_FFFF;
  localparam longint SMP_MAX     = 32767;
  localparam longint SMP_MIN     = -32768;
  localparam longint ALPHA_UNITY = 65536;
  localparam int     FRAC        = 16;
  localparam int     REPORT_MAX  = 10;

  typedef struct {
    logic signed [15:0] band;
    logic [14:0]        env;
  } band_result_t;

  typedef struct packed {
    logic signed [63:0] y;
    logic signed [63:0] s1;
    logic signed [63:0] s2;
  } section_t;

  longint hp_g, hp_a1, hp_a2, lp_g, lp_a1, lp_a2, alpha;
  longint hp_s1, hp_s2, lp_s1, lp_s2, env_acc;
  band_result_t expected_q[$];
  band_result_t want;
  int fail_count;

  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // transposed direct form II, one biquad
  function automatic section_t run_section(longint x, longint g, longint b1, longint a1,
                                           longint a2, longint s1, longint s2);
    section_t r;
    r.y  = clamp_acc(round_half_up(g * x, FRAC) + s1);
    r.s1 = clamp_acc(round_half_up(b1 * x - a1 * r.y, FRAC) + s2);
    r.s2 = clamp_acc(round_half_up(g * x - a2 * r.y, FRAC));
    return r;
  endfunction

  function automatic void predict_sample(logic signed [15:0] smp);
    section_t hp, lp;
    longint x, band, rect, lvl, e, a;
    band_result_t r;
    x = clamp_acc(longint'(smp) <<< FRAC);
    hp = run_section(x, hp_g, -2 * hp_g, hp_a1, hp_a2, hp_s1, hp_s2);
    lp = run_section(hp.y, lp_g, 2 * lp_g, lp_a1, lp_a2, lp_s1, lp_s2);
    hp_s1 = hp.s1;
    hp_s2 = hp.s2;
    lp_s1 = lp.s1;
    lp_s2 = lp.s2;
    band = round_half_up(lp.y, FRAC);
    if (band > SMP_MAX) band = SMP_MAX;
    else if (band < SMP_MIN) band = SMP_MIN;
    // rectify the saturated integer output
    rect = (band < 0 ? -band : band) <<< FRAC;
    a = (alpha > ALPHA_UNITY) ? ALPHA_UNITY : alpha;
    lvl = env_acc + round_half_up(a * (rect - env_acc), FRAC);
    if (lvl < 0) lvl = 0;
    else if (lvl > ENV_CEIL) lvl = ENV_CEIL;
    env_acc = lvl;
    e = round_half_up(lvl, FRAC);
    if (e > SMP_MAX) e = SMP_MAX;
    r.band = band[15:0];
    r.env  = e[14:0];
    expected_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hp_g    = longint'(bef_pkg::HP_GAIN_RST);
      hp_a1   = longint'(bef_pkg::HP_FB1_RST);
      hp_a2   = longint'(bef_pkg::HP_FB2_RST);
      lp_g    = longint'(bef_pkg::LP_GAIN_RST);
      lp_a1   = longint'(bef_pkg::LP_FB1_RST);
      lp_a2   = longint'(bef_pkg::LP_FB2_RST);
      alpha   = longint'(bef_pkg::ENV_ALPHA_RST);
      hp_s1   = 0;
      hp_s2   = 0;
      lp_s1   = 0;
      lp_s2   = 0;
      env_acc = 0;
      expected_q.delete();
      fail_count = 0;
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bef_pkg::REG_HP_GAIN:   hp_g  = longint'(cfg_data[16:0]);
          bef_pkg::REG_HP_FB1:    hp_a1 = longint'($signed(cfg_data));
          bef_pkg::REG_HP_FB2:    hp_a2 = longint'($signed(cfg_data));
          bef_pkg::REG_LP_GAIN:   lp_g  = longint'(cfg_data[16:0]);
          bef_pkg::REG_LP_FB1:    lp_a1 = longint'($signed(cfg_data));
          bef_pkg::REG_LP_FB2:    lp_a2 = longint'($signed(cfg_data));
          bef_pkg::REG_ENV_ALPHA: alpha = longint'(cfg_data[16:0]);
          default: ;
        endcase
      end
      if (din.valid && din.ready) predict_sample(din.sample);
      if (dout.valid && dout.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result transaction: band %0d envelope %0d",
                     dout.band_value, dout.envelope);
        end else begin
          want = expected_q.pop_front();
          if (want.band !== dout.band_value || want.env !== dout.envelope) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("result mismatch: expected band %0d envelope %0d, got band %0d envelope %0d",
                       want.band, want.env, dout.band_value, dout.envelope);
          end
        end
      end
      errors  <= fail_count;
      pending <= expected_q.size();
    end
  end

endmodule

/* test/bandpass_envelope_follower_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the bandpass envelope follower: clock, reset, register settings and
// sample stimulus with random idling; checking is done by bef_band_checker.
// Depends on bef_pkg, bef_in_if, bef_out_if, bef_band_checker and the block.
module bandpass_envelope_follower_tb;

  localparam logic [bef_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int BLOCK_LATENCY = 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 105;
  localparam int PHASES        = 8;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [bef_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bef_pkg::CFG_DATA_W-1:0] cfg_data;
  int  errors, pending;
  int  src_idle_pct, sink_stall_pct;
  bit  long_hold;
  int  burst_left, burst_shape, wave_period, wave_amp, wave_phase;

  bef_in_if  #(.SAMPLE_BITS(16)) din_ch ();
  bef_out_if #(.SAMPLE_BITS(16)) dout_ch ();

  bandpass_envelope_follower #(
    .SAMPLE_BITS(16),
    .COEF_FRAC_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .din(din_ch),
    .dout(dout_ch)
  );

  bef_band_checker chk (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .din(din_ch),
    .dout(dout_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        dout_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        dout_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
      default: begin src_idle_pct = 29; sink_stall_pct = 29; end
    endcase
  endtask

  task automatic send_sample(input logic signed [15:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid  <= 1'b1;
    din_ch.sample <= s;
    do @(posedge clk); while (!din_ch.ready);
  endtask

  task automatic wait_idle();
    din_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bef_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // gain and alpha registers get a random bit 17, which the block drops
  task automatic apply_setting(input int hg, input int ha1, input int ha2, input int lg,
                               input int la1, input int la2, input int alp);
    wait_idle();
    write_reg(bef_pkg::REG_HP_GAIN,   {1'($urandom_range(1)), hg[16:0]});
    write_reg(bef_pkg::REG_HP_FB1,    ha1[17:0]);
    write_reg(bef_pkg::REG_HP_FB2,    ha2[17:0]);
    write_reg(REG_UNUSED,             18'($urandom));
    write_reg(bef_pkg::REG_LP_GAIN,   {1'($urandom_range(1)), lg[16:0]});
    write_reg(bef_pkg::REG_LP_FB1,    la1[17:0]);
    write_reg(bef_pkg::REG_LP_FB2,    la2[17:0]);
    write_reg(bef_pkg::REG_ENV_ALPHA, {1'($urandom_range(1)), alp[16:0]});
    cfg_we <= 1'b0;
  endtask

  function automatic int jitter(input int base, input int span);
    return base + int'($urandom_range(2 * span)) - span;
  endfunction

  // bursts of square waves, wideband noise, small noise, extremes and steps
  function automatic logic signed [15:0] next_sample();
    int r, v;
    if (burst_left == 0) begin
      burst_left  = $urandom_range(8, 40);
      r           = $urandom_range(9);
      burst_shape = (r < 5) ? 0 : (r < 7) ? 1 : r - 5;
      wave_period = $urandom_range(2, 40);
      wave_amp    = $urandom_range(32767);
      wave_phase  = 0;
    end
    burst_left--;
    case (burst_shape)
      0: begin
        v = (wave_phase < wave_period / 2) ? wave_amp : -wave_amp;
        wave_phase = (wave_phase + 1) % wave_period;
      end
      1: v = $urandom;
      2: v = int'($urandom_range(600)) - 300;
      3: v = $urandom_range(1) ? 32767 : -32768;
      default: v = wave_amp - 16384;
    endcase
    return v[15:0];
  endfunction

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    din_ch.valid  <= 1'b0;
    din_ch.sample <= '0;
    long_hold      = 1'b0;
    burst_left     = 0;
    set_idling(0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: steps between extremes
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    repeat (5) send_sample(16'sd32767);

    // largest gains, alpha and fb1 (gains, alpha above range), fb2 at 1.0: drives the accumulators into saturation
    apply_setting(131071, 131071, 65536, 131071, 131071, 65536, 131071);
    repeat (3) begin
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
    end

    // smallest gains, alpha and fb1, fb2 at -1.0
    apply_setting(0, -131072, -65536, 0, -131072, -65536, 0);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd1);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        apply_setting(int'(bef_pkg::HP_GAIN_RST), int'(bef_pkg::HP_FB1_RST),
                      int'(bef_pkg::HP_FB2_RST), int'(bef_pkg::LP_GAIN_RST),
                      int'(bef_pkg::LP_FB1_RST), int'(bef_pkg::LP_FB2_RST),
                      int'(bef_pkg::ENV_ALPHA_RST));
      else if (p == 2)
        apply_setting(65536, int'(bef_pkg::HP_FB1_RST), int'(bef_pkg::HP_FB2_RST), 65536,
                      int'(bef_pkg::LP_FB1_RST), int'(bef_pkg::LP_FB2_RST), 65536);
      else if (p % 2 == 0)
        apply_setting(jitter(59963, 2000), jitter(-119452, 2000), jitter(54866, 2000),
                      jitter(3023, 2000), jitter(-85674, 2000), jitter(32231, 2000),
                      $urandom_range(131071));
      else
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      set_idling(p % 4);
      if (p == 0) long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) wait_idle();
        send_sample(next_sample());
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bef_pkg.sv
hdl/bef_in_if.sv
hdl/bef_out_if.sv
hdl/bef_mul.sv
hdl/bandpass_envelope_follower.sv
test/bef_band_checker.sv
test/bandpass_envelope_follower_tb.sv
